@@ sv/tdp_pkg.sv @@
package tdp_pkg;

  // Delay counter width; register values are taken modulo 2^DELAY_WIDTH
  localparam int DELAY_WIDTH = 16;

  localparam int NUM_LEVELS = 5;
  localparam int REG_WIDTH  = 16;
  localparam int GATE_WIDTH = 12;

  // Command / status codes
  localparam logic [7:0] CODE_OFF = 8'h0A;
  localparam logic [7:0] CODE_0C  = 8'h0C;
  localparam logic [7:0] CODE_0E  = 8'h0E;
  localparam logic [7:0] CODE_10  = 8'h10;
  localparam logic [7:0] CODE_12  = 8'h12;
  localparam logic [7:0] CODE_14  = 8'h14;

  // Level indexes
  typedef logic [2:0] level_t;
  localparam level_t LVL_OFF = 3'd0;
  localparam level_t LVL_0C  = 3'd1;
  localparam level_t LVL_0E  = 3'd2;
  localparam level_t LVL_10  = 3'd3;
  localparam level_t LVL_12  = 3'd4;
  localparam level_t LVL_14  = 3'd5;

  // Configuration register indexes
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t CFG_DELAY_0C   = 3'd0;
  localparam cfg_index_t CFG_DELAY_0E   = 3'd1;
  localparam cfg_index_t CFG_DELAY_10   = 3'd2;
  localparam cfg_index_t CFG_DELAY_12   = 3'd3;
  localparam cfg_index_t CFG_DELAY_14   = 3'd4;
  localparam cfg_index_t CFG_GATE_PULSE = 3'd5;

  // Register reset values
  localparam logic [REG_WIDTH-1:0]  RST_DELAY_0C   = 16'd7552;
  localparam logic [REG_WIDTH-1:0]  RST_DELAY_0E   = 16'd6528;
  localparam logic [REG_WIDTH-1:0]  RST_DELAY_10   = 16'd5504;
  localparam logic [REG_WIDTH-1:0]  RST_DELAY_12   = 16'd3968;
  localparam logic [REG_WIDTH-1:0]  RST_DELAY_14   = 16'd1496;
  localparam logic [GATE_WIDTH-1:0] RST_GATE_PULSE = 12'd200;

  typedef struct packed {
    logic       gate_drive;
    logic [7:0] status_byte;
    logic       delay_pending;
  } result_t;

  function automatic logic [7:0] level_code(input level_t lvl);
    logic [7:0] code;
    case (lvl)
      LVL_0C:  code = CODE_0C;
      LVL_0E:  code = CODE_0E;
      LVL_10:  code = CODE_10;
      LVL_12:  code = CODE_12;
      LVL_14:  code = CODE_14;
      default: code = CODE_OFF;
    endcase
    return code;
  endfunction

endpackage

@@ sv/tdp_core.sv @@
module tdp_core
  import tdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  zero_cross_level,
  input  logic                  cmd_valid,
  input  logic [7:0]            cmd_byte,
  input  logic [REG_WIDTH-1:0]  delay_reg [NUM_LEVELS],
  input  logic [GATE_WIDTH-1:0] gate_pulse_ticks,
  output result_t               result_next
);

  level_t                 level_index, level_index_next;
  logic                   previous_zero_cross;
  logic [DELAY_WIDTH-1:0] delay_counter, delay_counter_next;
  logic                   delay_running, delay_running_next;
  logic [GATE_WIDTH-1:0]  pulse_counter, pulse_counter_next;
  logic                   pulse_active, pulse_active_next;
  logic [DELAY_WIDTH-1:0] target;
  logic [DELAY_WIDTH-1:0] delay_inc;
  logic                   rise;

  assign rise      = zero_cross_level && !previous_zero_cross;
  assign delay_inc = delay_counter + DELAY_WIDTH'(1);

  always_comb begin
    level_index_next = level_index;
    if (cmd_valid) begin
      case (cmd_byte)
        CODE_OFF: level_index_next = LVL_OFF;
        CODE_0C:  level_index_next = LVL_0C;
        CODE_0E:  level_index_next = LVL_0E;
        CODE_10:  level_index_next = LVL_10;
        CODE_12:  level_index_next = LVL_12;
        CODE_14:  level_index_next = LVL_14;
        default:  level_index_next = level_index;
      endcase
    end
  end

  // Off level gives a zero target: a running delay fires on the current tick
  always_comb begin
    case (level_index_next)
      LVL_0C:  target = DELAY_WIDTH'(delay_reg[0]);
      LVL_0E:  target = DELAY_WIDTH'(delay_reg[1]);
      LVL_10:  target = DELAY_WIDTH'(delay_reg[2]);
      LVL_12:  target = DELAY_WIDTH'(delay_reg[3]);
      LVL_14:  target = DELAY_WIDTH'(delay_reg[4]);
      default: target = '0;
    endcase
  end

  always_comb begin
    pulse_active_next  = pulse_active;
    pulse_counter_next = pulse_counter;
    delay_counter_next = delay_counter;
    delay_running_next = delay_running;

    if (pulse_active) begin
      pulse_counter_next = pulse_counter + GATE_WIDTH'(1);
      if (pulse_counter_next >= gate_pulse_ticks) begin
        pulse_active_next = 1'b0;
      end
    end

    if (delay_running) begin
      delay_counter_next = delay_inc;
      if (delay_inc >= target) begin
        delay_running_next = 1'b0;
        delay_counter_next = '0;
        pulse_active_next  = 1'b1;
        pulse_counter_next = '0;
      end
    end

    // Edge restarts the delay, after any firing on this tick
    if (rise) begin
      delay_counter_next = '0;
      delay_running_next = (level_index_next != LVL_OFF);
    end
  end

  assign result_next.gate_drive    = pulse_active_next;
  assign result_next.status_byte   = level_code(level_index_next);
  assign result_next.delay_pending = delay_running_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_index         <= LVL_OFF;
      previous_zero_cross <= 1'b1;
      delay_counter       <= '0;
      delay_running       <= 1'b0;
      pulse_counter       <= '0;
      pulse_active        <= 1'b0;
    end else if (advance) begin
      level_index         <= level_index_next;
      previous_zero_cross <= zero_cross_level;
      delay_counter       <= delay_counter_next;
      delay_running       <= delay_running_next;
      pulse_counter       <= pulse_counter_next;
      pulse_active        <= pulse_active_next;
    end
  end

endmodule

@@ sv/triac_phase_angle_dimmer.sv @@
// A transfer's result is registered, shown to the master the next cycle.
// Throughput: one tick per cycle unless the master stalls; the tick update
// (command decode, pulse/delay counters, edge detect) is one combinational pass.
// Reset (rst, synchronous, active high): level off (status 0x0A), zero-cross
// history high, counters idle, config registers back to defaults, no result.
module triac_phase_angle_dimmer
  import tdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave side: one transfer per 1 us tick
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [0] zero_cross_level, [1] cmd_valid,
                                     // [9:2] cmd_byte, [15:10] zero
  // master side: one result per tick
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [0] gate_drive, [8:1] status_byte,
                                     // [9] delay_pending, [15:10] zero
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [REG_WIDTH-1:0]  delay_reg [NUM_LEVELS];
  logic [GATE_WIDTH-1:0] gate_pulse_ticks;
  logic                  in_xfer;
  result_t               result_next;
  result_t               result;
  logic                  out_valid;

  // Output register parts the two sides: a new tick is taken whenever the
  // held result is empty or leaving this cycle.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Config registers; indexes past the gate pulse register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_reg[0]     <= RST_DELAY_0C;
      delay_reg[1]     <= RST_DELAY_0E;
      delay_reg[2]     <= RST_DELAY_10;
      delay_reg[3]     <= RST_DELAY_12;
      delay_reg[4]     <= RST_DELAY_14;
      gate_pulse_ticks <= RST_GATE_PULSE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELAY_0C:   delay_reg[0]     <= cfg_data;
        CFG_DELAY_0E:   delay_reg[1]     <= cfg_data;
        CFG_DELAY_10:   delay_reg[2]     <= cfg_data;
        CFG_DELAY_12:   delay_reg[3]     <= cfg_data;
        CFG_DELAY_14:   delay_reg[4]     <= cfg_data;
        CFG_GATE_PULSE: gate_pulse_ticks <= cfg_data[GATE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Tick state and next-state logic
  tdp_core u_core (
    .clk              (clk),
    .rst              (rst),
    .advance          (in_xfer),
    .zero_cross_level (s_axis_tdata[0]),
    .cmd_valid        (s_axis_tdata[1]),
    .cmd_byte         (s_axis_tdata[9:2]),
    .delay_reg        (delay_reg),
    .gate_pulse_ticks (gate_pulse_ticks),
    .result_next      (result_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, result.delay_pending, result.status_byte,
                          result.gate_drive};

  // Off level never leaves a delay counting
  a_off_no_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.status_byte == CODE_OFF) |-> !result.delay_pending)
    else $error("delay pending while level is off");

  // Status always carries a legal level code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.status_byte == CODE_OFF || result.status_byte == CODE_0C ||
                   result.status_byte == CODE_0E || result.status_byte == CODE_10 ||
                   result.status_byte == CODE_12 || result.status_byte == CODE_14))
    else $error("illegal status code");

  // No result shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule
